// ===== rtl/core/spmf_pkg.sv =====
// Package for the strict-priority multi-level job queue.
// Holds request and status codes, field widths and parameter defaults.
// No dependencies.
package spmf_pkg;

   // Payload field widths
   localparam int JOB_W    = 16;
   localparam int LEVEL_W  = 3;
   localparam int TOTAL_W  = 8;
   localparam int STATUS_W = 2;

   // Defaults for the top-level parameters
   localparam int DEF_LEVELS          = 8;
   localparam int DEF_DEPTH_PER_LEVEL = 16;
   localparam int DEF_TAG_BITS        = 16;

   // Request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

// ===== rtl/core/spmf_level_table.sv =====
// Per-level queue descriptor table: head, tail and count of each level.
// Synchronous memory with written bits, plus the non-empty vector and the
// highest non-empty level. Depends on spmf_pkg.
module spmf_level_table
   import spmf_pkg::*;
#(
   parameter int LEVELS          = DEF_LEVELS,
   parameter int DEPTH_PER_LEVEL = DEF_DEPTH_PER_LEVEL,
   localparam int LVL_W = $clog2(LEVELS),
   localparam int PTR_W = $clog2(DEPTH_PER_LEVEL),
   localparam int CNT_W = $clog2(DEPTH_PER_LEVEL + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [LVL_W-1:0] rd_level,
   output logic [PTR_W-1:0] rd_head,
   output logic [PTR_W-1:0] rd_tail,
   output logic [CNT_W-1:0] rd_count,
   input  logic             wr_en,
   input  logic [LVL_W-1:0] wr_level,
   input  logic [PTR_W-1:0] wr_head,
   input  logic [PTR_W-1:0] wr_tail,
   input  logic [CNT_W-1:0] wr_count,
   output logic             top_valid,
   output logic [LVL_W-1:0] top_level
);

   localparam int ENT_W = 2 * PTR_W + CNT_W;

   logic [ENT_W-1:0]  desc_mem_ff [LEVELS];
   logic [LEVELS-1:0] written_ff;
   logic [LEVELS-1:0] nonempty_ff;
   logic [ENT_W-1:0]  ent_rd_ff;
   logic              ent_written_ff;
   logic [ENT_W-1:0]  ent_rd;

   // Descriptor memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem_ff[wr_level] <= {wr_head, wr_tail, wr_count};
      end
      if (rd_en) begin
         ent_rd_ff <= desc_mem_ff[rd_level];
      end
   end

   // Track written levels and non-empty levels
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff     <= '0;
         nonempty_ff    <= '0;
         ent_written_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            ent_written_ff <= written_ff[rd_level];
         end
         if (wr_en) begin
            written_ff[wr_level]  <= 1'b1;
            nonempty_ff[wr_level] <= (wr_count != '0);
         end
      end
   end

   // An unwritten level reads as all zero
   assign ent_rd = ent_written_ff ? ent_rd_ff : '0;
   assign rd_head  = ent_rd[ENT_W-1 -: PTR_W];
   assign rd_tail  = ent_rd[CNT_W +: PTR_W];
   assign rd_count = ent_rd[CNT_W-1:0];

   // Pick the highest non-empty level
   always_comb begin
      top_level = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            top_level = LVL_W'(i);
         end
      end
   end

   assign top_valid = |nonempty_ff;

endmodule

// ===== rtl/core/strict_priority_multi_fifo.sv =====
// Top level of the strict-priority multi-level job queue.
// Holds the job store memory, the request sequencer and the result register.
// Depends on spmf_pkg and spmf_level_table.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_ready   req_type, req_prio_level, req_job_tag
//   rsp_      out         rsp_valid/rsp_ready   rsp_status, rsp_out_job, rsp_out_level,
//                                               rsp_total_queued
//
// A push reads the level descriptor memory, then updates it and writes the job
// store; a pop reads the descriptor, then updates it and reads the job store, then
// takes the job store read data. One request is in work at a time.
// Reset clears the descriptor written bits, the counts and the sequencer; no
// memory sweep is needed. A stalled result holds the sequencer in its last
// step until the result register frees up.
module strict_priority_multi_fifo
   import spmf_pkg::*;
#(
   parameter int LEVELS          = DEF_LEVELS,
   parameter int DEPTH_PER_LEVEL = DEF_DEPTH_PER_LEVEL,
   parameter int TAG_BITS        = DEF_TAG_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [LEVEL_W-1:0]  req_prio_level,
   input  logic [JOB_W-1:0]    req_job_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [JOB_W-1:0]    rsp_out_job,
   output logic [LEVEL_W-1:0]  rsp_out_level,
   output logic [TOTAL_W-1:0]  rsp_total_queued
);

   localparam int SLOTS  = LEVELS * DEPTH_PER_LEVEL;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(DEPTH_PER_LEVEL);
   localparam int CNT_W  = $clog2(DEPTH_PER_LEVEL + 1);
   localparam int TOT_W  = $clog2(SLOTS + 1);
   localparam bit ALL_LEVELS_VALID = (LEVELS >= (1 << LEVEL_W));

   // Sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LEVEL = 2'd1;
   localparam logic [1:0] S_JOB   = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                is_pop_ff, is_pop_in;
   logic                refuse_ff, refuse_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]  out_lvl_ff, out_lvl_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [TOT_W-1:0]    total_ff, total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [JOB_W-1:0]    rsp_job_ff, rsp_job_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;

   logic [TAG_BITS-1:0] job_store_ff [SLOTS];
   logic [TAG_BITS-1:0] job_rd_ff;
   logic                job_rd_en, job_wr_en;
   logic [PTR_W-1:0]    job_ptr;
   logic [SLOT_W-1:0]   job_addr;

   logic                tab_rd_en, tab_wr_en;
   logic [PTR_W-1:0]    tab_head, tab_tail;
   logic [CNT_W-1:0]    tab_count;
   logic [PTR_W-1:0]    tab_wr_head, tab_wr_tail;
   logic [CNT_W-1:0]    tab_wr_count;
   logic                top_valid;
   logic [LVL_W-1:0]    top_level;

   logic                out_free;
   logic                in_range;
   logic                level_full;
   logic [PTR_W-1:0]    head_next, tail_next;

   spmf_level_table #(
      .LEVELS          (LEVELS),
      .DEPTH_PER_LEVEL (DEPTH_PER_LEVEL)
   ) u_level_table (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (tab_rd_en),
      .rd_level  (lvl_in),
      .rd_head   (tab_head),
      .rd_tail   (tab_tail),
      .rd_count  (tab_count),
      .wr_en     (tab_wr_en),
      .wr_level  (lvl_ff),
      .wr_head   (tab_wr_head),
      .wr_tail   (tab_wr_tail),
      .wr_count  (tab_wr_count),
      .top_valid (top_valid),
      .top_level (top_level)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = ALL_LEVELS_VALID || (32'(req_prio_level) < 32'(LEVELS));

   // Wrap the ring indices of the addressed level
   assign head_next  = (tab_head == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : tab_head + 1'b1;
   assign tail_next  = (tab_tail == PTR_W'(DEPTH_PER_LEVEL - 1)) ? '0 : tab_tail + 1'b1;
   assign level_full = (tab_count == CNT_W'(DEPTH_PER_LEVEL));

   // Slot address: level base plus ring index
   assign job_addr = SLOT_W'(lvl_ff) * SLOT_W'(DEPTH_PER_LEVEL) + SLOT_W'(job_ptr);

   // Sequence one request: read descriptor, update, deliver result
   always_comb begin
      state_in      = state_ff;
      is_pop_in     = is_pop_ff;
      refuse_in     = refuse_ff;
      lvl_in        = lvl_ff;
      out_lvl_in    = out_lvl_ff;
      tag_in        = tag_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_total_in  = rsp_total_ff;
      tab_rd_en     = 1'b0;
      tab_wr_en     = 1'b0;
      tab_wr_head   = tab_head;
      tab_wr_tail   = tab_tail;
      tab_wr_count  = tab_count;
      job_rd_en     = 1'b0;
      job_wr_en     = 1'b0;
      job_ptr       = tab_tail;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tab_rd_en = 1'b1;
               state_in  = S_LEVEL;
               is_pop_in = (req_type == REQ_POP);
               tag_in    = TAG_BITS'(req_job_tag);
               if (req_type == REQ_POP) begin
                  lvl_in     = top_level;
                  out_lvl_in = LEVEL_W'(top_level);
                  refuse_in  = !top_valid;
               end else begin
                  lvl_in     = LVL_W'(req_prio_level);
                  out_lvl_in = req_prio_level;
                  refuse_in  = !in_range;
               end
            end
         end
         S_LEVEL: begin
            if (is_pop_ff && !refuse_ff) begin
               // Pop: read the head slot and advance the head
               job_ptr      = tab_head;
               job_rd_en    = 1'b1;
               tab_wr_en    = 1'b1;
               tab_wr_head  = head_next;
               tab_wr_count = tab_count - 1'b1;
               total_in     = total_ff - 1'b1;
               state_in     = S_JOB;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_job_in   = '0;
               state_in     = S_IDLE;
               if (is_pop_ff) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_level_in  = '0;
                  rsp_total_in  = TOTAL_W'(total_ff);
               end else if (refuse_ff || level_full) begin
                  rsp_status_in = ST_FULL;
                  rsp_level_in  = out_lvl_ff;
                  rsp_total_in  = TOTAL_W'(total_ff);
               end else begin
                  // Push: write the tail slot and advance the tail
                  job_wr_en     = 1'b1;
                  tab_wr_en     = 1'b1;
                  tab_wr_tail   = tail_next;
                  tab_wr_count  = tab_count + 1'b1;
                  total_in      = total_ff + 1'b1;
                  rsp_status_in = ST_PUSHED;
                  rsp_level_in  = out_lvl_ff;
                  rsp_total_in  = TOTAL_W'(total_ff + 1'b1);
               end
            end
         end
         S_JOB: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_POPPED;
               rsp_job_in    = JOB_W'(job_rd_ff);
               rsp_level_in  = out_lvl_ff;
               rsp_total_in  = TOTAL_W'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Job store: one port, read data registered
   always_ff @(posedge clock) begin
      if (job_wr_en) begin
         job_store_ff[job_addr] <= tag_ff;
      end
      if (job_rd_en) begin
         job_rd_ff <= job_store_ff[job_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload registers
   always_ff @(posedge clock) begin
      is_pop_ff     <= is_pop_in;
      refuse_ff     <= refuse_in;
      lvl_ff        <= lvl_in;
      out_lvl_ff    <= out_lvl_in;
      tag_ff        <= tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_job      = rsp_job_ff;
   assign rsp_out_level    = rsp_level_ff;
   assign rsp_total_queued = rsp_total_ff;

`ifndef SYNTHESIS
   // The job read step only follows the descriptor step or holds
   a_job_after_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_JOB) |-> ($past(state_ff) == S_LEVEL || $past(state_ff) == S_JOB))
      else $error("job read step entered without descriptor step");

   // The total never exceeds the store capacity
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(SLOTS))
      else $error("total job count exceeds capacity");

   // An empty pop is only reported when nothing is queued
   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (total_ff == '0 && rsp_total_ff == '0))
      else $error("empty pop reported while jobs are queued");

   // An accepted request moves the sequencer into the descriptor step
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_LEVEL))
      else $error("accepted request did not start descriptor step");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for strict_priority_multi_fifo: directed table then random push/pop bursts.
// Checks each result against a per-level queue predictor; depends on spmf_pkg and the RTL.
// Random request gaps, response stalls and long receiver hold-offs exercise backpressure.
module tb;
   import spmf_pkg::*;

   localparam int LEVELS          = DEF_LEVELS;
   localparam int DEPTH           = DEF_DEPTH_PER_LEVEL;
   localparam int RANDOM_REQUESTS = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 11;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [JOB_W-1:0]    job;
      logic [LEVEL_W-1:0]  level;
      logic [TOTAL_W-1:0]  total;
   } queue_result_type;

   typedef struct {
      logic               kind;
      logic [LEVEL_W-1:0] level;
      logic [JOB_W-1:0]   tag;
      int                 reps;
      bit                 typed;
      queue_result_type   result;
   } stim_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_type;
   logic [LEVEL_W-1:0]  req_prio_level;
   logic [JOB_W-1:0]    req_job_tag;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [JOB_W-1:0]    rsp_out_job;
   logic [LEVEL_W-1:0]  rsp_out_level;
   logic [TOTAL_W-1:0]  rsp_total_queued;

   // Predictor state: one queue of job tags per level plus the total held
   logic [JOB_W-1:0] level_jobs [LEVELS][$];
   int               jobs_held;

   queue_result_type expected_results [$];
   stim_row_type     directed_rows [DIRECTED_ROWS];
   int               requests_sent;
   int               mismatches;
   int               seen_by_status [4];

   strict_priority_multi_fifo i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_prio_level   (req_prio_level),
      .req_job_tag      (req_job_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_job      (rsp_out_job),
      .rsp_out_level    (rsp_out_level),
      .rsp_total_queued (rsp_total_queued)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one request to the predicted queues and return the outcome
   function automatic queue_result_type predict_outcome(input logic kind,
                                                        input logic [LEVEL_W-1:0] lvl,
                                                        input logic [JOB_W-1:0] tag);
      queue_result_type r;
      int l;
      r = '0;
      if (kind == REQ_PUSH) begin
         r.level = lvl;
         if (level_jobs[lvl].size() >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            level_jobs[lvl].push_back(tag);
            jobs_held++;
            r.status = ST_PUSHED;
         end
      end else begin
         r.status = ST_EMPTY;
         for (l = LEVELS - 1; l >= 0; l--) begin
            if (level_jobs[l].size() > 0) begin
               r.status = ST_POPPED;
               r.job    = level_jobs[l].pop_front();
               r.level  = LEVEL_W'(l);
               jobs_held--;
               break;
            end
         end
      end
      r.total = TOTAL_W'(jobs_held);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input queue_result_type want,
                                input queue_result_type seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("tb: %s: expected status %0d job %h level %0d total %0d,",
                  what, want.status, want.job, want.level, want.total);
         $display("tb:    got status %0d job %h level %0d total %0d",
                  seen.status, seen.job, seen.level, seen.total);
      end
   endtask

   // Offer one request after a random gap, hold it until accepted, then predict it
   task automatic send_request(input logic kind, input logic [LEVEL_W-1:0] lvl,
                               input logic [JOB_W-1:0] tag, input bit typed,
                               input queue_result_type typed_result);
      int gap;
      queue_result_type want;
      gap = ((requests_sent % 200) < 40) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_prio_level <= lvl;
      req_job_tag    <= tag;
      do @(posedge clock); while (!req_ready);
      want = predict_outcome(kind, lvl, tag);
      if (typed) begin
         want = typed_result;
      end
      expected_results.push_back(want);
      requests_sent++;
   endtask

   // Check each accepted result against the oldest pending expectation
   always @(posedge clock) begin : check_results
      queue_result_type seen;
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_status, rsp_out_job, rsp_out_level, rsp_total_queued};
         seen_by_status[seen.status]++;
         if (expected_results.size() == 0) begin
            note_mismatch("result with no request pending", '0, seen);
         end else begin
            want = expected_results.pop_front();
            if (seen.status != want.status || seen.job != want.job ||
                seen.level != want.level || seen.total != want.total) begin
               note_mismatch("result mismatch", want, seen);
            end
         end
      end
   end

   // Result side: random stall per result, two long hold-offs to back up the block
   initial begin : drain_results
      int stall;
      int taken;
      rsp_ready = 1'b0;
      taken = 0;
      wait (reset == 1'b1);
      wait (reset == 1'b0);
      forever begin
         stall = ((taken % 250) >= 180) ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (taken == 400 || taken == 1400) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
      end
   end

   initial begin : run_stimulus
      int row;
      int k;
      int burst_len;
      int push_pct;
      int items;
      bit focused;
      logic [LEVEL_W-1:0] focus_lvl;
      logic kind;
      logic [LEVEL_W-1:0] lvl;
      logic [JOB_W-1:0] tag;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_PUSH;
      req_prio_level = '0;
      req_job_tag    = '0;
      jobs_held      = 0;
      requests_sent  = 0;
      mismatches     = 0;
      seen_by_status = '{0, 0, 0, 0};

      // Directed rows: empty pop, extreme tags and levels, a full level, priority order
      directed_rows[0]  = '{REQ_POP,  3'd0, 16'h0000, 1,  1'b1,
                            '{ST_EMPTY,  16'h0000, 3'd0, 8'd0}};
      directed_rows[1]  = '{REQ_PUSH, 3'd7, 16'hFFFF, 1,  1'b1,
                            '{ST_PUSHED, 16'h0000, 3'd7, 8'd1}};
      directed_rows[2]  = '{REQ_PUSH, 3'd0, 16'h0000, 1,  1'b1,
                            '{ST_PUSHED, 16'h0000, 3'd0, 8'd2}};
      directed_rows[3]  = '{REQ_POP,  3'd0, 16'hFFFF, 1,  1'b1,
                            '{ST_POPPED, 16'hFFFF, 3'd7, 8'd1}};
      directed_rows[4]  = '{REQ_POP,  3'd7, 16'h0000, 1,  1'b1,
                            '{ST_POPPED, 16'h0000, 3'd0, 8'd0}};
      directed_rows[5]  = '{REQ_POP,  3'd5, 16'h5555, 1,  1'b1,
                            '{ST_EMPTY,  16'h0000, 3'd0, 8'd0}};
      directed_rows[6]  = '{REQ_PUSH, 3'd3, 16'hA5A0, DEPTH, 1'b0, '0};
      directed_rows[7]  = '{REQ_PUSH, 3'd3, 16'h5A5A, 1,  1'b1,
                            '{ST_FULL,   16'h0000, 3'd3, 8'd16}};
      directed_rows[8]  = '{REQ_PUSH, 3'd5, 16'h1234, 1,  1'b0, '0};
      directed_rows[9]  = '{REQ_POP,  3'd0, 16'h0000, 1,  1'b1,
                            '{ST_POPPED, 16'h1234, 3'd5, 8'd16}};
      directed_rows[10] = '{REQ_POP,  3'd0, 16'h0000, 1,  1'b0, '0};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         for (k = 0; k < directed_rows[row].reps; k++) begin
            send_request(directed_rows[row].kind, directed_rows[row].level,
                         directed_rows[row].tag + JOB_W'(k), directed_rows[row].typed,
                         directed_rows[row].result);
         end
      end

      // Random bursts: fill, drain or balanced, some aimed at one level to reach full
      items = 0;
      while (items < RANDOM_REQUESTS) begin
         burst_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 20;
            default: push_pct = 50;
         endcase
         focused   = ($urandom_range(0, 9) < 3);
         focus_lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
         for (k = 0; k < burst_len && items < RANDOM_REQUESTS; k++) begin
            kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
            if (focused && $urandom_range(0, 9) < 8) begin
               lvl = focus_lvl;
            end else begin
               lvl = LEVEL_W'($urandom_range(0, LEVELS - 1));
            end
            case ($urandom_range(0, 9))
               0: tag = '0;
               1: tag = '1;
               default: tag = JOB_W'($urandom_range(0, 65535));
            endcase
            send_request(kind, lvl, tag, 1'b0, '0);
            items++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Wait out the remaining results, then keep watching for strays
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d requests sent, results: %0d pushed, %0d popped,",
               requests_sent, seen_by_status[ST_PUSHED], seen_by_status[ST_POPPED]);
      $display("tb: %0d empty pops, %0d refused pushes, %0d mismatches",
               seen_by_status[ST_EMPTY], seen_by_status[ST_FULL], mismatches);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Give up if the run hangs
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== strict_priority_multi_fifo.f =====
rtl/core/spmf_pkg.sv
rtl/core/spmf_level_table.sv
rtl/core/strict_priority_multi_fifo.sv
bench/tb.sv
